>>> rtl/r2t_pkg.sv
// ---------------------------------------------------------------------------
// r2t_pkg: shared types and constants
// Field widths, mode codes, register indexes and the controller/datapath
// command and status bundles of the raster to tile scan converter.
// ---------------------------------------------------------------------------
package r2t_pkg;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 5;
  localparam int SIZE_W   = 9;
  localparam int ADDR_W   = 18;
  localparam int TILE_W   = 5;
  localparam int DIMREG_W = 10;
  localparam int CNTREG_W = 5;
  localparam int APB_AW   = 5;

  localparam logic [MODE_W-1:0] MODE_COL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONV = 2'd2;
  // undefined mode, accepted and dropped
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_COLS_M1 = 3'd2;
  localparam logic [2:0] REG_ROWS_M1 = 3'd3;
  localparam logic [2:0] REG_UNIFORM = 3'd4;

  typedef struct packed {
    logic [DIMREG_W-1:0] width_in_ctb;
    logic [DIMREG_W-1:0] height_in_ctb;
    logic [CNTREG_W-1:0] tile_cols_minus1;
    logic [CNTREG_W-1:0] tile_rows_minus1;
    logic                uniform_spacing;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_step;
    logic save_tb;
    logic set_ax;
    logic ax_val;
    logic ndiv_load;
    logic winit;
    logic walk_step;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_conv;
    logic bad_now;
    logic uniform;
    logic div_last;
    logic walk_last;
    logic ax;
    logic mul_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/r2t_ram.sv
// ---------------------------------------------------------------------------
// r2t_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module r2t_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/r2t_ctrl.sv
// ---------------------------------------------------------------------------
// r2t_ctrl: conversion sequencer
// Steps the datapath through bound check, divisions, tile walks,
// address accumulation and result hand-off.
// ---------------------------------------------------------------------------
module r2t_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  r2t_pkg::status_t  status,
  output r2t_pkg::cmd_t     cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_DIVA  = 10'b0000000100,
    S_SAVE  = 10'b0000001000,
    S_NDIV  = 10'b0000010000,
    S_WINIT = 10'b0000100000,
    S_WALK  = 10'b0001000000,
    S_AXIS  = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = accept;
        if (accept && status.in_conv) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.bad_now ? S_OUT : S_DIVA;
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd.save_tb   = 1'b1;
        cmd.set_ax    = 1'b1;
        cmd.ax_val    = 1'b0;
        cmd.ndiv_load = 1'b1;
        state_next    = status.uniform ? S_NDIV : S_WINIT;
      end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_WINIT;
        end
      end
      S_WINIT: begin
        cmd.winit  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = status.ax ? S_MUL : S_AXIS;
        end
      end
      S_AXIS: begin
        cmd.set_ax    = 1'b1;
        cmd.ax_val    = 1'b1;
        cmd.ndiv_load = 1'b1;
        state_next    = status.uniform ? S_NDIV : S_WINIT;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/r2t_dp.sv
// ---------------------------------------------------------------------------
// r2t_dp: conversion datapath
// Size stores, shared restoring divider, tile boundary walker,
// multiply-accumulate for the tile scan address and the result register.
// ---------------------------------------------------------------------------
module r2t_dp #(
  parameter int MAX_TILE_COLS = 20,
  parameter int MAX_TILE_ROWS = 22,
  parameter int MAX_PIC_DIM   = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  r2t_pkg::cfg_t                 cfg,
  input  logic [31:0]                   s_tdata,
  input  logic [r2t_pkg::MODE_W-1:0]    s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [31:0]                   m_tdata,
  output logic                          m_tuser,
  input  r2t_pkg::cmd_t                 cmd,
  output r2t_pkg::status_t              status
);

  localparam int ADDR_W = r2t_pkg::ADDR_W;
  localparam int SIZE_W = r2t_pkg::SIZE_W;
  localparam int TILE_W = r2t_pkg::TILE_W;
  localparam int DIM_W  = $clog2(MAX_PIC_DIM + 1);
  localparam int MAXN   = (MAX_TILE_COLS > MAX_TILE_ROWS) ? MAX_TILE_COLS : MAX_TILE_ROWS;
  localparam int CNT_W  = $clog2(MAXN + 1);
  localparam int DV_W   = (DIM_W > CNT_W) ? DIM_W : CNT_W;
  localparam int CA_W   = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int RA_W   = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
  localparam int PROD_W = 2 * DIM_W;
  localparam int CMP_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
  localparam int ACC_W  = 2 * DIM_W + 2;
  localparam int S_W    = ((DIM_W > SIZE_W) ? DIM_W : SIZE_W) + 1;
  localparam int DC_W   = $clog2(ADDR_W);

  // input item fields
  logic [r2t_pkg::IDX_W-1:0] in_idx;
  logic [SIZE_W-1:0]         in_size;
  logic [ADDR_W-1:0]         in_addr;

  assign in_idx  = s_tdata[4:0];
  assign in_size = s_tdata[13:5];
  assign in_addr = s_tdata[31:14];

  // latched item and clamped geometry
  logic [ADDR_W-1:0] addr;
  logic [DIM_W-1:0]  w, h, w_c, h_c;
  logic [CNT_W-1:0]  nc, nr, nc_c, nr_c;
  logic              uni;
  logic              bad;

  always_comb begin
    w_c = (32'(cfg.width_in_ctb) > MAX_PIC_DIM) ? DIM_W'(MAX_PIC_DIM)
                                                : DIM_W'(cfg.width_in_ctb);
    h_c = (32'(cfg.height_in_ctb) > MAX_PIC_DIM) ? DIM_W'(MAX_PIC_DIM)
                                                 : DIM_W'(cfg.height_in_ctb);
    if (32'(cfg.tile_cols_minus1) > MAX_TILE_COLS - 1) begin
      nc_c = CNT_W'(MAX_TILE_COLS);
    end else begin
      nc_c = CNT_W'(cfg.tile_cols_minus1) + 1'b1;
    end
    if (32'(cfg.tile_rows_minus1) > MAX_TILE_ROWS - 1) begin
      nr_c = CNT_W'(MAX_TILE_ROWS);
    end else begin
      nr_c = CNT_W'(cfg.tile_rows_minus1) + 1'b1;
    end
  end

  // size stores
  logic              col_we, row_we;
  logic [CNT_W-1:0]  rd_idx;
  logic [SIZE_W-1:0] col_q, row_q;

  assign col_we = cmd.load && (s_tuser == r2t_pkg::MODE_COL) && (32'(in_idx) < MAX_TILE_COLS);
  assign row_we = cmd.load && (s_tuser == r2t_pkg::MODE_ROW) && (32'(in_idx) < MAX_TILE_ROWS);

  r2t_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_TILE_COLS)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (CA_W'(in_idx)),
    .wdata (in_size),
    .raddr (CA_W'(rd_idx)),
    .rdata (col_q)
  );

  r2t_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_TILE_ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (RA_W'(in_idx)),
    .wdata (in_size),
    .raddr (RA_W'(rd_idx)),
    .rdata (row_q)
  );

  // bound check
  logic [PROD_W-1:0] wh;
  logic              bad_now;

  assign wh      = PROD_W'(w) * PROD_W'(h);
  assign bad_now = (w == '0) || (h == '0) || (CMP_W'(addr) >= CMP_W'(wh));

  // axis selection
  logic             ax, sel_ax;
  logic [DIM_W-1:0] dim_a, dim_l, tgt;
  logic [CNT_W-1:0] n_a, n_l;
  logic [SIZE_W-1:0] size_a;
  logic [DIM_W-1:0] tbx, tby;

  assign sel_ax = cmd.set_ax ? cmd.ax_val : ax;
  assign dim_a  = ax ? h : w;
  assign n_a    = ax ? nr : nc;
  assign tgt    = ax ? tby : tbx;
  assign size_a = ax ? row_q : col_q;
  assign dim_l  = sel_ax ? h : w;
  assign n_l    = sel_ax ? nr : nc;

  // shared restoring divider, one quotient bit per cycle
  logic [DV_W-1:0]   dv_rem, dv_div;
  logic [ADDR_W-1:0] dv_quo;
  logic [DC_W-1:0]   dv_cnt;
  logic [DV_W:0]     dv_sh, dv_diff;
  logic              dv_ge;

  assign dv_sh   = {dv_rem, dv_quo[ADDR_W-1]};
  assign dv_diff = dv_sh - {1'b0, dv_div};
  assign dv_ge   = !dv_diff[DV_W];

  // boundary walker
  logic [CNT_W-1:0] i;
  logic [DIM_W-1:0] lo, q, qd, hq, hi_e, hi;
  logic [DV_W-1:0]  r, rd, r_n;
  logic [DV_W:0]    rs;
  logic             ge_n, last;
  logic [S_W-1:0]   s_sum;
  logic [CNT_W-1:0] i_inc;

  assign i_inc  = i + 1'b1;
  assign last   = (i == n_a - 1'b1);
  assign rd_idx = (cmd.walk_step && (i_inc < n_a)) ? i_inc : '0;

  always_comb begin
    rs    = {1'b0, r} + {1'b0, rd};
    ge_n  = (rs >= (DV_W + 1)'(n_a));
    r_n   = ge_n ? DV_W'(rs - (DV_W + 1)'(n_a)) : DV_W'(rs);
    hq    = q + qd + DIM_W'(ge_n);
    s_sum = S_W'(lo) + S_W'(size_a) + 1'b1;
    if (last) begin
      hi_e = dim_a;
    end else if (s_sum > S_W'(dim_a)) begin
      hi_e = dim_a;
    end else begin
      hi_e = DIM_W'(s_sum);
    end
    hi = uni ? hq : hi_e;
  end

  logic [CNT_W-1:0] tx, ty;
  logic [DIM_W-1:0] clo, chi, rlo, rhi;

  // address accumulation: one product per cycle
  logic [1:0]        k;
  logic [DIM_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;

  always_comb begin
    case (k)
      2'd0: begin
        mul_a = w;
        mul_b = rlo;
      end
      2'd1: begin
        mul_a = rhi - rlo;
        mul_b = clo;
      end
      default: begin
        mul_a = tby - rlo;
        mul_b = chi - clo;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // result register
  logic [ADDR_W-1:0] o_ts;
  logic [TILE_W-1:0] o_col, o_row;
  logic              o_bad;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= in_addr;
      w    <= w_c;
      h    <= h_c;
      nc   <= nc_c;
      nr   <= nr_c;
      uni  <= cfg.uniform_spacing;
    end
    if (cmd.check) begin
      bad    <= bad_now;
      dv_rem <= '0;
      dv_quo <= addr;
      dv_div <= DV_W'(w);
      dv_cnt <= '0;
    end else if (cmd.ndiv_load) begin
      dv_rem <= '0;
      dv_quo <= ADDR_W'(dim_l);
      dv_div <= DV_W'(n_l);
      dv_cnt <= '0;
    end else if (cmd.div_step) begin
      dv_rem <= dv_ge ? dv_diff[DV_W-1:0] : dv_sh[DV_W-1:0];
      dv_quo <= {dv_quo[ADDR_W-2:0], dv_ge};
      dv_cnt <= dv_cnt + 1'b1;
    end
    if (cmd.set_ax) begin
      ax <= cmd.ax_val;
    end
    if (cmd.save_tb) begin
      tbx <= DIM_W'(dv_rem);
      tby <= DIM_W'(dv_quo);
    end
    if (cmd.winit) begin
      qd <= DIM_W'(dv_quo);
      rd <= dv_rem;
      i  <= '0;
      lo <= '0;
      q  <= '0;
      r  <= '0;
      k  <= '0;
    end else if (cmd.walk_step) begin
      lo <= hi;
      q  <= hq;
      r  <= r_n;
      i  <= i_inc;
      if (tgt >= lo) begin
        if (ax) begin
          ty  <= i;
          rlo <= lo;
          rhi <= hi;
        end else begin
          tx  <= i;
          clo <= lo;
          chi <= hi;
        end
      end
    end else if (cmd.mul_step) begin
      k   <= k + 1'b1;
      acc <= ((k == 2'd0) ? ACC_W'(tbx - clo) : acc) + ACC_W'(prod);
    end
    if (cmd.out_load) begin
      o_ts  <= bad ? '0 : ADDR_W'(acc);
      o_col <= bad ? '0 : TILE_W'(tx);
      o_row <= bad ? '0 : TILE_W'(ty);
      o_bad <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0, o_row, o_col, o_ts};
  assign m_tuser = o_bad;

  assign status.in_conv   = (s_tuser == r2t_pkg::MODE_CONV);
  assign status.bad_now   = bad_now;
  assign status.uniform   = uni;
  assign status.div_last  = (dv_cnt == DC_W'(ADDR_W - 1));
  assign status.walk_last = last;
  assign status.ax        = ax;
  assign status.mul_last  = (k == 2'd2);
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

>>> rtl/raster_to_tile_scan_address_core.sv
// ---------------------------------------------------------------------------
// raster_to_tile_scan_address_core: CTB raster to tile scan converter
// Maps a CTB raster address to its tile scan address, tile column and row,
// with uniform or explicitly sized tiles.
// ---------------------------------------------------------------------------
//  channel  | direction | content
//  s_*      | in        | tdata: entry_index, entry_size_minus1, raster_address;
//           |           | tuser: mode
//  m_*      | out       | tdata: tile_scan_address, tile_column, tile_row;
//           |           | tuser: bad_address
//  apb      | in/out    | width, height, tile counts, uniform spacing
//
// a conversion holds the input while the 18-step serial divisions (three
// uniform, one explicit) and the one-tile-per-cycle boundary walks run; a bad
// address goes from the bound check straight to the output register.
// a stalled output adds its stall; a result waits in the output register
// while the next item is taken. rst clears the sequencer, the result valid
// and the registers.
// ---------------------------------------------------------------------------
module raster_to_tile_scan_address_core #(
  parameter int MAX_TILE_COLS = 20,
  parameter int MAX_TILE_ROWS = 22,
  parameter int MAX_PIC_DIM   = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // entry_index, entry_size_minus1, raster_address
  input  logic [31:0]                 s_tdata,
  // mode
  input  logic [r2t_pkg::MODE_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // tile_scan_address, tile_column, tile_row, zero pad
  output logic [31:0]                 m_tdata,
  // bad_address
  output logic                        m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [r2t_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  r2t_pkg::cfg_t    cfg;
  r2t_pkg::cmd_t    cmd;
  r2t_pkg::status_t status;
  logic             cfg_we;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_in_ctb     <= 10'd1;
      cfg.height_in_ctb    <= 10'd1;
      cfg.tile_cols_minus1 <= '0;
      cfg.tile_rows_minus1 <= '0;
      cfg.uniform_spacing  <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx)
        r2t_pkg::REG_WIDTH:   cfg.width_in_ctb     <= pwdata[9:0];
        r2t_pkg::REG_HEIGHT:  cfg.height_in_ctb    <= pwdata[9:0];
        r2t_pkg::REG_COLS_M1: cfg.tile_cols_minus1 <= pwdata[4:0];
        r2t_pkg::REG_ROWS_M1: cfg.tile_rows_minus1 <= pwdata[4:0];
        r2t_pkg::REG_UNIFORM: cfg.uniform_spacing  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      r2t_pkg::REG_WIDTH:   prdata = 32'(cfg.width_in_ctb);
      r2t_pkg::REG_HEIGHT:  prdata = 32'(cfg.height_in_ctb);
      r2t_pkg::REG_COLS_M1: prdata = 32'(cfg.tile_cols_minus1);
      r2t_pkg::REG_ROWS_M1: prdata = 32'(cfg.tile_rows_minus1);
      r2t_pkg::REG_UNIFORM: prdata = 32'(cfg.uniform_spacing);
      default:              prdata = '0;
    endcase
  end

  r2t_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  r2t_dp #(
    .MAX_TILE_COLS (MAX_TILE_COLS),
    .MAX_TILE_ROWS (MAX_TILE_ROWS),
    .MAX_PIC_DIM   (MAX_PIC_DIM)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  // a flagged address carries an all-zero payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("bad address transaction with nonzero payload");

  // a conversion keeps the input side closed while it runs
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == r2t_pkg::MODE_CONV |=> !s_tready)
    else $error("input taken during conversion");

  // reported tile column stays inside the configured range or below MAX_TILE_COLS
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[22:18]) <= 32'(cfg.tile_cols_minus1)
                 || 32'(m_tdata[22:18]) < MAX_TILE_COLS)
    else $error("tile column out of range");

endmodule

>>> bench/raster_to_tile_scan_address_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raster_to_tile_scan_address_checker: result predictor and comparator
// Watches the input, output and register channels of the converter, keeps
// its own copy of the tile layout, predicts every conversion result and
// compares the results in order, field by field.
// ---------------------------------------------------------------------------
module raster_to_tile_scan_address_checker #(
  parameter int MAX_TILE_COLS = 20,
  parameter int MAX_TILE_ROWS = 22,
  parameter int MAX_PIC_DIM   = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);

  localparam int BD_LAST = (MAX_TILE_COLS > MAX_TILE_ROWS) ? MAX_TILE_COLS : MAX_TILE_ROWS;
  localparam int PEND_D  = 16;

  typedef struct packed {
    logic [r2t_pkg::ADDR_W-1:0] scan_addr;
    logic [r2t_pkg::TILE_W-1:0] col;
    logic [r2t_pkg::TILE_W-1:0] row;
    logic                       bad;
  } tile_pos_t;

  r2t_pkg::cfg_t layout;
  int            col_size_m1 [MAX_TILE_COLS];
  int            row_size_m1 [MAX_TILE_ROWS];
  // expected results in order of their input transactions
  tile_pos_t     pending_pos [PEND_D];
  int            pend_wr = 0;
  int            pend_rd = 0;

  assign pending_count = pend_wr - pend_rd;

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void tile_bounds(output int bd[0:BD_LAST], input int n, input int dim,
                                      input logic uni, input bit is_col);
    int nxt;
    bd[0] = 0;
    for (int i = 0; i < n; i++) begin
      if (uni) nxt = ((i + 1) * dim) / n;
      else if (i + 1 == n) nxt = dim;
      else begin
        nxt = bd[i] + (is_col ? col_size_m1[i] : row_size_m1[i]) + 1;
        if (nxt > dim) nxt = dim;
      end
      bd[i + 1] = nxt;
    end
  endfunction

  function automatic tile_pos_t locate_ctb(input int addr);
    tile_pos_t p;
    int w, h, nc, nr, x, y, tx, ty, ts;
    int cb[0:BD_LAST];
    int rb[0:BD_LAST];
    p = '0;
    w = (layout.width_in_ctb > MAX_PIC_DIM) ? MAX_PIC_DIM : layout.width_in_ctb;
    h = (layout.height_in_ctb > MAX_PIC_DIM) ? MAX_PIC_DIM : layout.height_in_ctb;
    nc = ((layout.tile_cols_minus1 > MAX_TILE_COLS - 1) ? MAX_TILE_COLS - 1
          : layout.tile_cols_minus1) + 1;
    nr = ((layout.tile_rows_minus1 > MAX_TILE_ROWS - 1) ? MAX_TILE_ROWS - 1
          : layout.tile_rows_minus1) + 1;
    if (w == 0 || h == 0 || addr >= w * h) begin
      p.bad = 1'b1;
      return p;
    end
    tile_bounds(cb, nc, w, layout.uniform_spacing, 1'b1);
    tile_bounds(rb, nr, h, layout.uniform_spacing, 1'b0);
    x = addr % w;
    y = addr / w;
    tx = 0;
    ty = 0;
    for (int i = 0; i < nc; i++) if (x >= cb[i]) tx = i;
    for (int i = 0; i < nr; i++) if (y >= rb[i]) ty = i;
    ts = w * rb[ty] + (rb[ty+1] - rb[ty]) * cb[tx]
       + (y - rb[ty]) * (cb[tx+1] - cb[tx]) + (x - cb[tx]);
    p.scan_addr = ts[r2t_pkg::ADDR_W-1:0];
    p.col = tx[r2t_pkg::TILE_W-1:0];
    p.row = ty[r2t_pkg::TILE_W-1:0];
    return p;
  endfunction

  always @(posedge clk) begin
    tile_pos_t want;
    int idx;
    if (rst) begin
      layout <= '{width_in_ctb: 1, height_in_ctb: 1, tile_cols_minus1: 0,
                  tile_rows_minus1: 0, uniform_spacing: 1};
      fail_count <= 0;
      pend_wr = 0;
      pend_rd = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          r2t_pkg::REG_WIDTH:   layout.width_in_ctb <= pwdata[9:0];
          r2t_pkg::REG_HEIGHT:  layout.height_in_ctb <= pwdata[9:0];
          r2t_pkg::REG_COLS_M1: layout.tile_cols_minus1 <= pwdata[4:0];
          r2t_pkg::REG_ROWS_M1: layout.tile_rows_minus1 <= pwdata[4:0];
          r2t_pkg::REG_UNIFORM: layout.uniform_spacing <= pwdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        idx = s_tdata[4:0];
        case (s_tuser)
          r2t_pkg::MODE_COL: if (idx < MAX_TILE_COLS) col_size_m1[idx] = s_tdata[13:5];
          r2t_pkg::MODE_ROW: if (idx < MAX_TILE_ROWS) row_size_m1[idx] = s_tdata[13:5];
          r2t_pkg::MODE_CONV: begin
            pending_pos[pend_wr % PEND_D] = locate_ctb(s_tdata[31:14]);
            pend_wr++;
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (pend_wr == pend_rd) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          want = pending_pos[pend_rd % PEND_D];
          pend_rd++;
          if (m_tdata[17:0] !== want.scan_addr)
            report("tile_scan_address", m_tdata[17:0], want.scan_addr);
          if (m_tdata[22:18] !== want.col) report("tile_column", m_tdata[22:18], want.col);
          if (m_tdata[27:23] !== want.row) report("tile_row", m_tdata[27:23], want.row);
          if (m_tuser !== want.bad) report("bad_address", m_tuser, want.bad);
        end
      end
    end
  end

endmodule

>>> bench/raster_to_tile_scan_address_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raster_to_tile_scan_address_core_tb: converter testbench
// Programs a series of tile layouts over the register port, writes explicit
// tile sizes and sends directed and random conversions with random gaps on
// both channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module raster_to_tile_scan_address_core_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tuser, pready;
  logic [31:0] s_tdata = '0, m_tdata, pwdata = '0, prdata;
  logic [1:0]  s_tuser = '0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  int          fail_count, pending_count;
  int          pic_w, pic_h, n_cols, n_rows;
  int          rx_wait;

  always #5 clk = ~clk;

  raster_to_tile_scan_address_core u_top (.*);

  raster_to_tile_scan_address_checker u_chk (.*);

  // receiver waits a drawn number of cycles before each result
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      draw = $urandom_range(0, 7);
      rx_wait  <= draw;
      m_tready <= (draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input int value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays up into the next item when it follows with no gap
  task automatic send_item(input logic [1:0] mode, input int idx, input int sz,
                           input int addr);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {addr[17:0], sz[8:0], idx[4:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // program a layout, then fill every explicit entry that may be read
  task automatic set_layout(input int w, input int h, input int c, input int r,
                            input int uni);
    wait_idle();
    pic_w = w; pic_h = h; n_cols = c; n_rows = r;
    reg_write(r2t_pkg::REG_WIDTH, w);
    reg_write(r2t_pkg::REG_HEIGHT, h);
    reg_write(r2t_pkg::REG_COLS_M1, c);
    reg_write(r2t_pkg::REG_ROWS_M1, r);
    reg_write(r2t_pkg::REG_UNIFORM, uni);
    for (int i = 0; i < 20; i++)
      send_item(r2t_pkg::MODE_COL, i,
                (i % 3 == 0) ? $urandom_range(0, 511) : $urandom_range(0, 15), 0);
    for (int i = 0; i < 22; i++)
      send_item(r2t_pkg::MODE_ROW, i,
                (i % 3 == 0) ? $urandom_range(0, 511) : $urandom_range(0, 15), 0);
  endtask

  function automatic int pick_addr();
    int area;
    area = pic_w * pic_h;
    if (area == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 262143);
    if ($urandom_range(0, 9) == 0) return area - 1;
    return $urandom_range(0, area - 1);
  endfunction

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed: reset layout, then extremes and special cases
    send_item(r2t_pkg::MODE_CONV, 0, 0, 0);
    send_item(r2t_pkg::MODE_CONV, 31, 511, 262143);
    send_item(r2t_pkg::MODE_RSVD, 31, 511, 0);
    set_layout(512, 512, 19, 21, 1);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 0);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 262143);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 512 * 512 - 1);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 200000);
    set_layout(1023, 1023, 31, 31, 0);
    send_item(r2t_pkg::MODE_COL, 31, 511, 0);
    send_item(r2t_pkg::MODE_ROW, 22, 511, 0);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 262143);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 77777);
    set_layout(0, 7, 3, 2, 1);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 0);
    set_layout(5, 3, 7, 9, 0);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 14);
    send_item(r2t_pkg::MODE_CONV, 0, 0, 15);
    // random phases
    for (int ph = 0; ph < 19; ph++) begin
      if (ph % 4 == 3) set_layout($urandom_range(1, 512), $urandom_range(1, 512),
                                  $urandom_range(0, 31), $urandom_range(0, 31),
                                  $urandom_range(0, 1));
      else set_layout($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 1));
      for (int k = 0; k < 20; k++) begin
        case ($urandom_range(0, 9))
          0: send_item(r2t_pkg::MODE_RSVD, $urandom_range(0, 31), $urandom_range(0, 511),
                       $urandom_range(0, 262143));
          1: send_item(r2t_pkg::MODE_COL, $urandom_range(0, 31), $urandom_range(0, 511), 0);
          2: send_item(r2t_pkg::MODE_ROW, $urandom_range(0, 31), $urandom_range(0, 511), 0);
          default: send_item(r2t_pkg::MODE_CONV, $urandom_range(0, 31),
                             $urandom_range(0, 511), pick_addr());
        endcase
      end
    end
    wait_idle();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/r2t_pkg.sv
rtl/r2t_ram.sv
rtl/r2t_ctrl.sv
rtl/r2t_dp.sv
rtl/raster_to_tile_scan_address_core.sv
bench/raster_to_tile_scan_address_checker.sv
bench/raster_to_tile_scan_address_core_tb.sv
